// ===== rtl/nlg_pkg.sv =====
package nlg_pkg;

  localparam logic [31:0] VSCALE = 32'd429496730;
  localparam logic [31:0] TSCALE = 32'd515396076;
  localparam logic [31:0] ESCALE = 32'd8589935;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  localparam int unsigned NM_DIV = 31;

  typedef struct packed {
    logic        opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic        degenerate;
  } out_item_t;

  // work carried down the cell row
  typedef struct packed {
    logic        vld;
    logic        tri_mode;
    logic        degen;
    logic signed [33:0] base_x;
    logic signed [33:0] base_y;
    logic signed [33:0] base_z;
    logic signed [33:0] n_x;
    logic signed [33:0] n_y;
    logic signed [33:0] n_z;
    logic [2:0]  neg;
    logic [29:0] cm_x;
    logic [29:0] cm_y;
    logic [29:0] cm_z;
    logic [61:0] rem;
    logic [31:0] root;
    logic [47:0] rx;
    logic [47:0] ry;
    logic [47:0] rz;
    logic [17:0] qx;
    logic [17:0] qy;
    logic [17:0] qz;
    logic [31:0] eps;
    logic [31:0] len;
  } work_t;

endpackage

// ===== rtl/nlg_cell.sv =====
module nlg_cell
  import nlg_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  work_t din,
  output work_t dout
);

  work_t w;

  // one step: a sqrt digit for idx < 31, then one quotient bit for each component
  function automatic void dstep(input logic [47:0] r, input logic [31:0] d,
                                output logic [47:0] ro, output logic q);
    logic [48:0] t;
    t = {r, 1'b0} - {17'd0, d};
    if (!t[48]) begin
      ro = t[47:0];
      q = 1'b1;
    end else begin
      ro = {r[46:0], 1'b0};
      q = 1'b0;
    end
  endfunction

  always_comb begin
    logic [63:0] trial;
    logic [63:0] remx;
    logic [47:0] r0;
    logic q0;
    logic [4:0] sh;
    w = din;
    trial = '0;
    remx = '0;
    r0 = '0;
    q0 = 1'b0;
    sh = '0;
    if (IDX < NM_DIV) begin
      sh = 5'(30 - IDX);
      remx = {2'b0, din.rem};
      trial = {32'd0, din.root} << (sh + 5'd1);
      trial = trial | (64'd1 << (2 * sh));
      if (remx >= trial) begin
        w.rem = 62'(remx - trial);
        w.root = din.root | (32'd1 << sh);
      end
    end else begin
      dstep(din.rx, din.root, r0, q0);
      w.rx = r0;
      w.qx = {din.qx[16:0], q0};
      dstep(din.ry, din.root, r0, q0);
      w.ry = r0;
      w.qy = {din.qy[16:0], q0};
      dstep(din.rz, din.root, r0, q0);
      w.rz = r0;
      w.qz = {din.qz[16:0], q0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.tri_mode <= w.tri_mode;
    dout.degen <= w.degen;
    dout.base_x <= w.base_x;
    dout.base_y <= w.base_y;
    dout.base_z <= w.base_z;
    dout.n_x <= w.n_x;
    dout.n_y <= w.n_y;
    dout.n_z <= w.n_z;
    dout.neg <= w.neg;
    dout.cm_x <= w.cm_x;
    dout.cm_y <= w.cm_y;
    dout.cm_z <= w.cm_z;
    dout.rem <= w.rem;
    dout.root <= w.root;
    dout.rx <= w.rx;
    dout.ry <= w.ry;
    dout.rz <= w.rz;
    dout.qx <= w.qx;
    dout.qy <= w.qy;
    dout.qz <= w.qz;
    dout.eps <= w.eps;
    dout.len <= w.len;
  end

endmodule

// ===== rtl/normal_line_generator.sv =====
// normal_line_generator
// throughput: one item per clock, busy stays low; set by a row of 49 square-root
//   and divide cells, one digit or quotient bit per cell
// reset: synchronous active-high rst clears the pipeline valids and sets the size to 1.0
// the receiver cannot stall: result and result_valid last one cycle
module normal_line_generator
  import nlg_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [30:0] cfg_data,
  output logic      result_valid,
  output out_item_t result
);

  localparam int unsigned EW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int unsigned NCELL = 31 + 18;

  logic [30:0] csize;
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      csize <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      csize <= cfg_data;
    end
  end

  function automatic logic signed [33:0] sx(input logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << (32 - EW)) >>> (32 - EW);
    return 34'(t);
  endfunction

  function automatic logic [33:0] mag(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [31:0] scl(input logic [30:0] s, input logic [31:0] k);
    logic [63:0] p;
    p = {33'd0, s} * {32'd0, k} + 64'h8000_0000;
    return p[63:32];
  endfunction

  // quotient carries two extra fraction bits, round half up on the first
  function automatic logic [33:0] qround(input logic [17:0] q);
    return 34'(({2'b0, q[17:1]} + 19'd1) >> 1);
  endfunction

  // ---------- front stages ----------
  // s1: sign extension, sums, differences
  logic        v1, op1;
  logic signed [33:0] s1 [3];
  logic signed [33:0] u1 [3];
  logic signed [33:0] w1 [3];
  logic [31:0] eps1, len1;
  logic [30:0] seff;
  assign seff = (csize == 31'd0) ? 31'd1 : csize;

  always_ff @(posedge clk) begin
    logic signed [33:0] a [3];
    logic signed [33:0] b [3];
    logic signed [33:0] c [3];
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
    a[0] = sx(item.a_x); a[1] = sx(item.a_y); a[2] = sx(item.a_z);
    b[0] = sx(item.b_x); b[1] = sx(item.b_y); b[2] = sx(item.b_z);
    c[0] = sx(item.c_x); c[1] = sx(item.c_y); c[2] = sx(item.c_z);
    op1 <= (item.opcode == OP_TRIANGLE);
    for (int i = 0; i < 3; i++) begin
      s1[i] <= (item.opcode == OP_TRIANGLE) ? a[i] + b[i] + c[i] : a[i];
      u1[i] <= (item.opcode == OP_TRIANGLE) ? b[i] - a[i] : b[i];
      w1[i] <= c[i] - a[i];
    end
    eps1 <= scl(seff, ESCALE);
    len1 <= scl(seff, (item.opcode == OP_TRIANGLE) ? TSCALE : VSCALE);
  end

  // s2: centroid (reciprocal multiply), edge scaling to below 2^30
  logic        v2, op2;
  logic signed [33:0] bs2 [3];
  logic signed [33:0] nv2 [3];
  logic signed [30:0] u2 [3];
  logic signed [30:0] w2 [3];
  logic [31:0] eps2, len2;

  always_ff @(posedge clk) begin
    logic [33:0] m, um, wm, mx, q;
    logic [67:0] p;
    logic [1:0]  k;
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    op2 <= op1; eps2 <= eps1; len2 <= len1;
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      um = mag(u1[i]); wm = mag(w1[i]);
      mx = mx | um | wm;
    end
    k = mx[33] ? 2'd3 : (mx[32] ? 2'd2 : (mx[31] ? 2'd1 : (mx[30] ? 2'd1 : 2'd0)));
    if (mx[33]) k = 2'd3;
    for (int i = 0; i < 3; i++) begin
      m = mag(s1[i]) + 34'd1;
      p = {34'd0, m} * 68'h2_AAAA_AAAB;
      q = p[67:34] >> 0;
      q = 34'(p[67:35]);
      bs2[i] <= op1 ? (s1[i][33] ? -$signed(q) : $signed(q)) : s1[i];
      nv2[i] <= u1[i];
      um = mag(u1[i]) >> (mx >= 34'h8000_0000 ? (mx[33] ? 4 : (mx[32] ? 3 : 2)) :
                          (mx[30] ? 1 : 0));
      wm = mag(w1[i]) >> (mx >= 34'h8000_0000 ? (mx[33] ? 4 : (mx[32] ? 3 : 2)) :
                          (mx[30] ? 1 : 0));
      u2[i] <= u1[i][33] ? -$signed({1'b0, um[29:0]}) : $signed({1'b0, um[29:0]});
      w2[i] <= w1[i][33] ? -$signed({1'b0, wm[29:0]}) : $signed({1'b0, wm[29:0]});
    end
    if (k == 2'd0) mx = mx;
  end

  // s3: products
  logic        v3, op3;
  logic signed [33:0] bs3 [3];
  logic signed [33:0] nv3 [3];
  logic signed [61:0] pp [6];
  logic [31:0] eps3, len3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    op3 <= op2; eps3 <= eps2; len3 <= len2; bs3 <= bs2; nv3 <= nv2;
    pp[0] <= u2[1] * w2[2]; pp[1] <= u2[2] * w2[1];
    pp[2] <= u2[2] * w2[0]; pp[3] <= u2[0] * w2[2];
    pp[4] <= u2[0] * w2[1]; pp[5] <= u2[1] * w2[0];
  end

  // s4: cross product magnitudes
  logic        v4, op4;
  logic signed [33:0] bs4 [3];
  logic signed [33:0] nv4 [3];
  logic [61:0] cm4 [3];
  logic [2:0]  ng4;
  logic [31:0] eps4, len4;

  always_ff @(posedge clk) begin
    logic signed [62:0] cr;
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    op4 <= op3; eps4 <= eps3; len4 <= len3; bs4 <= bs3; nv4 <= nv3;
    for (int i = 0; i < 3; i++) begin
      cr = 63'(pp[2*i]) - 63'(pp[2*i+1]);
      ng4[i] <= cr[62];
      cm4[i] <= cr[62] ? 62'(-cr) : 62'(cr);
    end
  end

  // s5: normalize cross magnitudes so the largest lies in [2^29, 2^30)
  logic        v5, op5, dg5;
  logic signed [33:0] bs5 [3];
  logic signed [33:0] nv5 [3];
  logic [29:0] cm5 [3];
  logic [2:0]  ng5;
  logic [31:0] eps5, len5;

  always_ff @(posedge clk) begin
    logic [61:0] mx;
    logic [5:0]  lz;
    logic [91:0] t;
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    op5 <= op4; eps5 <= eps4; len5 <= len4; bs5 <= bs4; nv5 <= nv4; ng5 <= ng4;
    mx = cm4[0] | cm4[1] | cm4[2];
    lz = '0;
    for (int j = 0; j < 62; j++) if (mx[j]) lz = 6'(j);
    dg5 <= (mx == '0);
    for (int i = 0; i < 3; i++) begin
      t = {cm4[i], 30'd0} >> (lz + 6'd1);
      cm5[i] <= t[29:0];
    end
  end

  // s6: sum of squares
  logic        v6, op6, dg6;
  logic signed [33:0] bs6 [3];
  logic signed [33:0] nv6 [3];
  logic [29:0] cm6 [3];
  logic [61:0] sq6 [3];
  logic [2:0]  ng6;
  logic [31:0] eps6, len6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    op6 <= op5; dg6 <= dg5; eps6 <= eps5; len6 <= len5; bs6 <= bs5; nv6 <= nv5;
    cm6 <= cm5; ng6 <= ng5;
    for (int i = 0; i < 3; i++) sq6[i] <= {32'd0, cm5[i]} * {32'd0, cm5[i]};
  end

  // ---------- cell row: sqrt then divides ----------
  work_t row [NCELL+1];

  always_comb begin
    row[0] = '0;
    row[0].vld = v6;
    row[0].tri_mode = op6;
    row[0].degen = op6 && dg6;
    row[0].base_x = bs6[0]; row[0].base_y = bs6[1]; row[0].base_z = bs6[2];
    row[0].n_x = nv6[0]; row[0].n_y = nv6[1]; row[0].n_z = nv6[2];
    row[0].neg = ng6;
    row[0].cm_x = cm6[0]; row[0].cm_y = cm6[1]; row[0].cm_z = cm6[2];
    row[0].rem = 62'(sq6[0] + sq6[1] + sq6[2]);
    row[0].eps = eps6; row[0].len = len6;
  end

  // seed the divide remainders between sqrt and divide cells
  work_t seed;
  always_comb begin
    seed = row[NM_DIV];
    seed.rx = {18'd0, seed.cm_x};
    seed.ry = {18'd0, seed.cm_y};
    seed.rz = {18'd0, seed.cm_z};
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == NM_DIV) begin : g_seed
      nlg_cell #(.IDX(g)) u_cell (.clk(clk), .rst(rst), .din(seed), .dout(row[g+1]));
    end else begin : g_plain
      nlg_cell #(.IDX(g)) u_cell (.clk(clk), .rst(rst), .din(row[g]), .dout(row[g+1]));
    end
  end

  // ---------- back stages ----------
  // b1: signed unit normal (vertex normal passed through, +z for degenerate)
  logic        v7, op7, dg7;
  logic signed [33:0] bs7 [3];
  logic signed [33:0] n7 [3];
  logic [31:0] eps7, len7;

  always_ff @(posedge clk) begin
    work_t r;
    logic signed [33:0] q [3];
    r = row[NCELL];
    if (rst) v7 <= 1'b0;
    else v7 <= r.vld;
    op7 <= r.tri_mode; dg7 <= r.degen; eps7 <= r.eps; len7 <= r.len;
    bs7[0] <= r.base_x; bs7[1] <= r.base_y; bs7[2] <= r.base_z;
    q[0] = r.neg[0] ? -$signed(qround(r.qx)) : $signed(qround(r.qx));
    q[1] = r.neg[1] ? -$signed(qround(r.qy)) : $signed(qround(r.qy));
    q[2] = r.neg[2] ? -$signed(qround(r.qz)) : $signed(qround(r.qz));
    if (!r.tri_mode) begin
      n7[0] <= r.n_x; n7[1] <= r.n_y; n7[2] <= r.n_z;
    end else if (r.degen) begin
      n7[0] <= '0; n7[1] <= '0; n7[2] <= 34'sd65536;
    end else begin
      n7 <= q;
    end
  end

  // b2: dot and flip (triangle normals are at most 17 bits)
  logic        v8, dg8;
  logic signed [33:0] bs8 [3];
  logic signed [33:0] n8 [3];
  logic [31:0] eps8, len8;

  always_ff @(posedge clk) begin
    logic signed [53:0] dot;
    logic signed [53:0] pr;
    if (rst) v8 <= 1'b0;
    else v8 <= v7;
    dg8 <= dg7; eps8 <= eps7; len8 <= len7; bs8 <= bs7;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      pr = $signed(n7[i][18:0]) * bs7[i];
      dot = dot + pr;
    end
    for (int i = 0; i < 3; i++) n8[i] <= (op7 && dot < 0) ? -n7[i] : n7[i];
  end

  // b3: scaled terms
  logic        v9, dg9;
  logic signed [33:0] bs9 [3];
  logic signed [45:0] te9 [3];
  logic signed [45:0] tl9 [3];

  always_ff @(posedge clk) begin
    logic signed [66:0] p;
    logic [66:0] m;
    if (rst) v9 <= 1'b0;
    else v9 <= v8;
    dg9 <= dg8; bs9 <= bs8;
    for (int i = 0; i < 3; i++) begin
      p = n8[i] * $signed({1'b0, eps8});
      m = (p[66] ? 67'(-p) : 67'(p)) + 67'd32768;
      te9[i] <= p[66] ? -$signed(46'(m >> 16)) : $signed(46'(m >> 16));
      p = n8[i] * $signed({1'b0, len8});
      m = (p[66] ? 67'(-p) : 67'(p)) + 67'd32768;
      tl9[i] <= p[66] ? -$signed(46'(m >> 16)) : $signed(46'(m >> 16));
    end
  end

  function automatic logic [31:0] sat(input logic signed [47:0] x);
    logic signed [47:0] hi, lo;
    hi = 48'((64'sd1 <<< (EW - 1)) - 1);
    lo = -hi - 48'sd1;
    if (x > hi) return 32'(hi);
    if (x < lo) return 32'(lo);
    return 32'(x);
  endfunction

  always_ff @(posedge clk) begin
    logic signed [47:0] st;
    logic [31:0] so [3];
    logic [31:0] eo [3];
    if (rst) result_valid <= 1'b0;
    else result_valid <= v9;
    for (int i = 0; i < 3; i++) begin
      st = 48'(bs9[i]) + 48'(te9[i]);
      so[i] = sat(st);
      eo[i] = sat(st + 48'(tl9[i]));
    end
    result.start_x <= so[0]; result.start_y <= so[1]; result.start_z <= so[2];
    result.end_x <= eo[0]; result.end_y <= eo[1]; result.end_z <= eo[2];
    result.degenerate <= dg9;
  end

  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> (csize == $past(cfg_data)))
    else $error("size write lost");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    v6 |-> ##(NCELL + 4) result_valid)
    else $error("item lost in pipeline");

endmodule
